/* design/wffd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wffd_pkg: shared types and constants of the workgroup dispatcher
// Sizes, opcodes, status codes, register indexes and the descriptor layout.
// ----------------------------------------------------------------------------
package wffd_pkg;

  localparam int SM_COUNT   = 8;
  localparam int FIFO_DEPTH = 8;

  localparam int SM_IW  = (SM_COUNT > 1) ? $clog2(SM_COUNT) : 1;
  localparam int FP_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] LDS_RST   = 16'hFFFF;
  localparam logic [11:0] SGPR_RST  = 12'hFFF;
  localparam logic [11:0] VGPR_RST  = 12'hFFF;
  localparam logic [5:0]  WARPS_RST = 6'd32;

  typedef enum logic [1:0] {
    OP_ENQ      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_RELOAD   = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    STS_ENQUEUED   = 3'd0,
    STS_REFUSED    = 3'd1,
    STS_DISPATCHED = 3'd2,
    STS_NO_FIT     = 3'd3,
    STS_EMPTY      = 3'd4,
    STS_RELOADED   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_LDS   = 2'd0,
    CFG_SGPR  = 2'd1,
    CFG_VGPR  = 2'd2,
    CFG_WARPS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] vgpr;
    logic [11:0] sgpr;
    logic [15:0] lds;
    logic [5:0]  warps;
    logic [15:0] id;
  } wg_desc_t;

  function automatic logic [FP_W-1:0] ptr_bump(input logic [FP_W-1:0] p);
    logic [FP_W-1:0] r;
    if (p == FP_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

/* design/workgroup_first_fit_dispatcher.sv */
`timescale 1ns / 1ps
// Each transaction passes from IDLE through EXEC, then SCAN for a dispatch with a
// non-empty FIFO, then DONE; a dispatch scans up to SM_COUNT SM records through
// the shared fit comparator. DONE holds while a result waits on out_tready, and a
// new transaction is taken only back in IDLE; in_tready is high only when idle.
// Reset (rst_n low, synchronous): FIFO empty, all SMs free with reset resources,
// registers at reset values, no result pending.
// ----------------------------------------------------------------------------
// workgroup_first_fit_dispatcher: first-fit workgroup dispatcher
// Queues workgroup descriptors and places the head on the first free SM whose
// remaining resources cover it, scanning SM records through one comparator.
// ----------------------------------------------------------------------------
module workgroup_first_fit_dispatcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // wg_id[15:0], wg_warps[21:16], wg_lds[37:22], wg_sgpr[49:38], wg_vgpr[61:50]
  input  logic [63:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sm_index[2:0], dispatched_id[18:3], first_warp[23:19], warp_count[29:24],
  // any_sm_free[30], fifo_level[34:31]
  output logic [39:0] out_tdata,
  // status[2:0]
  output logic [2:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  import wffd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] lds_cfg_r;
  logic [11:0] sgpr_cfg_r;
  logic [11:0] vgpr_cfg_r;
  logic [5:0]  warps_cfg_r;

  opcode_t     op_r;
  wg_desc_t    desc_r;
  wg_desc_t    fifo_mem [FIFO_DEPTH];
  logic [FP_W-1:0]  head_r, tail_r;
  logic [CNT_W-1:0] count_r;

  logic [SM_COUNT-1:0] sm_busy_r;
  logic [15:0] lds_left_r   [SM_COUNT];
  logic [11:0] sgpr_left_r  [SM_COUNT];
  logic [11:0] vgpr_left_r  [SM_COUNT];
  logic [5:0]  warps_left_r [SM_COUNT];
  logic [5:0]  next_slot_r  [SM_COUNT];

  logic [SM_IW-1:0] scan_idx_r;

  status_t     res_status_r;
  logic [2:0]  res_sm_r;
  logic [15:0] res_id_r;
  logic [4:0]  res_fw_r;
  logic [5:0]  res_wc_r;

  logic        out_tvalid_r;
  status_t     out_status_r;
  logic [2:0]  out_sm_r;
  logic [15:0] out_id_r;
  logic [4:0]  out_fw_r;
  logic [5:0]  out_wc_r;
  logic        out_free_r;
  logic [3:0]  out_level_r;

  logic        fit;
  logic        scan_last;
  logic        out_slot_free;
  logic [31:0] idx_wide;
  logic [31:0] count_wide;

  assign fit           = !sm_busy_r[scan_idx_r]
                      && (desc_r.lds   <= lds_left_r[scan_idx_r])
                      && (desc_r.sgpr  <= sgpr_left_r[scan_idx_r])
                      && (desc_r.vgpr  <= vgpr_left_r[scan_idx_r])
                      && (desc_r.warps <= warps_left_r[scan_idx_r]);
  assign scan_last     = (scan_idx_r == SM_IW'(SM_COUNT - 1));
  assign out_slot_free = !out_tvalid_r || out_tready;
  assign idx_wide      = 32'(scan_idx_r);
  assign count_wide    = 32'(count_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'b0, out_level_r, out_free_r, out_wc_r, out_fw_r, out_id_r, out_sm_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lds_cfg_r   <= LDS_RST;
      sgpr_cfg_r  <= SGPR_RST;
      vgpr_cfg_r  <= VGPR_RST;
      warps_cfg_r <= WARPS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LDS:   lds_cfg_r   <= cfg_wdata;
        CFG_SGPR:  sgpr_cfg_r  <= cfg_wdata[11:0];
        CFG_VGPR:  vgpr_cfg_r  <= cfg_wdata[11:0];
        CFG_WARPS: warps_cfg_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_r == OP_DISPATCH && count_r != '0) state_nxt = ST_SCAN;
        else state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (fit || scan_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      sm_busy_r    <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < SM_COUNT; i++) begin
        lds_left_r[i]   <= LDS_RST;
        sgpr_left_r[i]  <= SGPR_RST;
        vgpr_left_r[i]  <= VGPR_RST;
        warps_left_r[i] <= WARPS_RST;
        next_slot_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_tvalid_r && out_tready && state_r != ST_DONE) out_tvalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            op_r   <= opcode_t'(in_tuser);
            desc_r <= wg_desc_t'(in_tdata[61:0]);
          end
        end
        ST_EXEC: begin
          res_sm_r   <= '0;
          res_id_r   <= '0;
          res_fw_r   <= '0;
          res_wc_r   <= '0;
          scan_idx_r <= '0;
          case (op_r)
            OP_ENQ: begin
              if (count_r == CNT_W'(FIFO_DEPTH)) begin
                res_status_r <= STS_REFUSED;
              end else begin
                fifo_mem[tail_r] <= desc_r;
                tail_r           <= ptr_bump(tail_r);
                count_r          <= count_r + 1'b1;
                res_status_r     <= STS_ENQUEUED;
              end
            end
            OP_DISPATCH: begin
              if (count_r == '0) res_status_r <= STS_EMPTY;
              else desc_r <= fifo_mem[head_r];
            end
            OP_RELOAD: begin
              sm_busy_r <= '0;
              for (int i = 0; i < SM_COUNT; i++) begin
                lds_left_r[i]   <= lds_cfg_r;
                sgpr_left_r[i]  <= sgpr_cfg_r;
                vgpr_left_r[i]  <= vgpr_cfg_r;
                warps_left_r[i] <= warps_cfg_r;
                next_slot_r[i]  <= '0;
              end
              res_status_r <= STS_RELOADED;
            end
            default: res_status_r <= STS_REFUSED;
          endcase
        end
        ST_SCAN: begin
          if (fit) begin
            sm_busy_r[scan_idx_r]    <= 1'b1;
            lds_left_r[scan_idx_r]   <= lds_left_r[scan_idx_r] - desc_r.lds;
            sgpr_left_r[scan_idx_r]  <= sgpr_left_r[scan_idx_r] - desc_r.sgpr;
            vgpr_left_r[scan_idx_r]  <= vgpr_left_r[scan_idx_r] - desc_r.vgpr;
            warps_left_r[scan_idx_r] <= warps_left_r[scan_idx_r] - desc_r.warps;
            next_slot_r[scan_idx_r]  <= next_slot_r[scan_idx_r] + desc_r.warps;
            head_r       <= ptr_bump(head_r);
            count_r      <= count_r - 1'b1;
            res_status_r <= STS_DISPATCHED;
            res_sm_r     <= idx_wide[2:0];
            res_id_r     <= desc_r.id;
            res_fw_r     <= next_slot_r[scan_idx_r][4:0];
            res_wc_r     <= desc_r.warps;
          end else if (scan_last) begin
            res_status_r <= STS_NO_FIT;
          end else begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_slot_free) begin
            out_tvalid_r <= 1'b1;
            out_status_r <= res_status_r;
            out_sm_r     <= res_sm_r;
            out_id_r     <= res_id_r;
            out_fw_r     <= res_fw_r;
            out_wc_r     <= res_wc_r;
            out_free_r   <= ~&sm_busy_r;
            out_level_r  <= count_wide[3:0];
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("descriptor count exceeds FIFO depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(FIFO_DEPTH)) |-> head_r == tail_r)
    else $error("FIFO pointers disagree with count");

  a_pick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && fit) |=> sm_busy_r[$past(scan_idx_r)])
    else $error("dispatched SM not marked busy");

  a_reload_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && op_r == OP_RELOAD) |=> sm_busy_r == '0)
    else $error("reload left an SM busy");
`endif

endmodule

/* verif/tb_workgroup_first_fit_dispatcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_workgroup_first_fit_dispatcher: self-checking bench for the dispatcher
// Drives enqueue, dispatch and reload requests under several resource settings
// and checks every result against a first-fit scheduler kept in the bench.
// The sender idles in bursts, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_workgroup_first_fit_dispatcher;
  import wffd_pkg::*;

  localparam int          QUIET_LIMIT = 2000;
  localparam int          DRAIN_TAIL  = 20;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    wg_desc_t   desc;
  } wg_request_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  sm;
    logic [15:0] wg_id;
    logic [4:0]  first_warp;
    logic [5:0]  warp_count;
    logic        any_free;
    logic [3:0]  level;
  } placement_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_wdata  = '0;

  // scheduler state
  logic [15:0] lds_cfg, lds_left [SM_COUNT];
  logic [11:0] sgpr_cfg, sgpr_left [SM_COUNT];
  logic [11:0] vgpr_cfg, vgpr_left [SM_COUNT];
  logic [5:0]  warps_cfg, warps_left [SM_COUNT];
  logic [5:0]  warp_slot [SM_COUNT];
  logic        sm_taken [SM_COUNT];
  wg_desc_t    pending_wg [FIFO_DEPTH];
  int          wg_head, wg_tail, wg_count;

  wg_request_t request_q [$];
  placement_t  placement_q [$];
  int          error_count = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  int          rx_hold_left = 0;

  workgroup_first_fit_dispatcher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void restore_sms();
    for (int i = 0; i < SM_COUNT; i++) begin
      sm_taken[i]   = 1'b0;
      lds_left[i]   = lds_cfg;
      sgpr_left[i]  = sgpr_cfg;
      vgpr_left[i]  = vgpr_cfg;
      warps_left[i] = warps_cfg;
      warp_slot[i]  = '0;
    end
  endfunction

  function automatic void reset_scheduler();
    lds_cfg   = LDS_RST;
    sgpr_cfg  = SGPR_RST;
    vgpr_cfg  = VGPR_RST;
    warps_cfg = WARPS_RST;
    wg_head   = 0;
    wg_tail   = 0;
    wg_count  = 0;
    restore_sms();
  endfunction

  function automatic placement_t predict_placement(input wg_request_t req);
    placement_t r;
    wg_desc_t   h;
    int         pick;
    r = '0;
    r.status = STS_REFUSED;
    if (req.op == OP_ENQ) begin
      if (wg_count < FIFO_DEPTH) begin
        pending_wg[wg_tail] = req.desc;
        wg_tail = (wg_tail + 1) % FIFO_DEPTH;
        wg_count++;
        r.status = STS_ENQUEUED;
      end
    end else if (req.op == OP_DISPATCH) begin
      if (wg_count == 0) begin
        r.status = STS_EMPTY;
      end else begin
        h = pending_wg[wg_head];
        pick = -1;
        for (int i = 0; i < SM_COUNT; i++) begin
          if (pick < 0 && !sm_taken[i] && h.lds <= lds_left[i] && h.sgpr <= sgpr_left[i] &&
              h.vgpr <= vgpr_left[i] && h.warps <= warps_left[i]) begin
            pick = i;
          end
        end
        if (pick < 0) begin
          r.status = STS_NO_FIT;
        end else begin
          sm_taken[pick]   = 1'b1;
          lds_left[pick]   = lds_left[pick] - h.lds;
          sgpr_left[pick]  = sgpr_left[pick] - h.sgpr;
          vgpr_left[pick]  = vgpr_left[pick] - h.vgpr;
          warps_left[pick] = warps_left[pick] - h.warps;
          r.first_warp     = warp_slot[pick][4:0];
          warp_slot[pick]  = warp_slot[pick] + h.warps;
          r.warp_count     = h.warps;
          r.wg_id          = h.id;
          r.sm             = 3'(pick);
          wg_head = (wg_head + 1) % FIFO_DEPTH;
          wg_count--;
          r.status = STS_DISPATCHED;
        end
      end
    end else if (req.op == OP_RELOAD) begin
      restore_sms();
      r.status = STS_RELOADED;
    end
    r.any_free = 1'b0;
    for (int i = 0; i < SM_COUNT; i++) begin
      if (!sm_taken[i]) r.any_free = 1'b1;
    end
    r.level = 4'(wg_count);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    error_count++;
  endtask

  task automatic check_placement(input placement_t got);
    placement_t want;
    if (placement_q.size() == 0) begin
      report_mismatch("unexpected result, status", 16'(got.status), '0);
    end else begin
      want = placement_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 16'(got.status), 16'(want.status));
      if (got.sm !== want.sm) report_mismatch("sm_index", 16'(got.sm), 16'(want.sm));
      if (got.wg_id !== want.wg_id) report_mismatch("dispatched_id", got.wg_id, want.wg_id);
      if (got.first_warp !== want.first_warp)
        report_mismatch("first_warp", 16'(got.first_warp), 16'(want.first_warp));
      if (got.warp_count !== want.warp_count)
        report_mismatch("warp_count", 16'(got.warp_count), 16'(want.warp_count));
      if (got.any_free !== want.any_free)
        report_mismatch("any_sm_free", 16'(got.any_free), 16'(want.any_free));
      if (got.level !== want.level)
        report_mismatch("fifo_level", 16'(got.level), 16'(want.level));
    end
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        placement_q.insert(placement_q.size(), predict_placement(request_q.pop_front()));
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tuser  <= request_q[0].op;
          in_tdata  <= {2'b00, request_q[0].desc};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    placement_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status     = status_t'(out_tuser);
        got.sm         = out_tdata[2:0];
        got.wg_id      = out_tdata[18:3];
        got.first_warp = out_tdata[23:19];
        got.warp_count = out_tdata[29:24];
        got.any_free   = out_tdata[30];
        got.level      = out_tdata[34:31];
        check_placement(got);
        results_seen++;
        if (results_seen % 500 == 150) rx_hold_left = 300;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(8, 64);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_tready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_request(input logic [1:0] op, input wg_desc_t d);
    wg_request_t req;
    req.op   = op;
    req.desc = d;
    request_q.insert(request_q.size(), req);
  endtask

  function automatic wg_desc_t pick_workgroup();
    wg_desc_t d;
    d.id = 16'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      d.warps = 6'($urandom_range(0, 32));
      d.lds   = 16'($urandom);
      d.sgpr  = 12'($urandom);
      d.vgpr  = 12'($urandom);
    end else begin
      d.warps = 6'($urandom_range(0, warps_cfg));
      d.lds   = 16'($urandom_range(0, lds_cfg));
      d.sgpr  = 12'($urandom_range(0, sgpr_cfg));
      d.vgpr  = 12'($urandom_range(0, vgpr_cfg));
    end
    return d;
  endfunction

  // groups of enqueues followed by dispatches, with reloads and stray requests
  task automatic queue_traffic(input int n);
    int left;
    int k;
    left = n;
    while (left > 0) begin
      k = $urandom_range(1, 9);
      for (int i = 0; i < k && left > 0; i++, left--) queue_request(OP_ENQ, pick_workgroup());
      k = $urandom_range(1, 10);
      for (int i = 0; i < k && left > 0; i++, left--) queue_request(OP_DISPATCH, pick_workgroup());
      if (left > 0 && $urandom_range(0, 2) == 0) begin
        queue_request(OP_RELOAD, pick_workgroup());
        left--;
      end
      if (left > 0 && $urandom_range(0, 15) == 0) begin
        queue_request(($urandom_range(0, 1) == 0) ? OP_UNUSED : OP_DISPATCH, pick_workgroup());
        left--;
      end
    end
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || placement_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_LDS:   lds_cfg   = value;
      CFG_SGPR:  sgpr_cfg  = value[11:0];
      CFG_VGPR:  vgpr_cfg  = value[11:0];
      default:   warps_cfg = value[5:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_resources(input logic [15:0] lds, input logic [15:0] sgpr,
                               input logic [15:0] vgpr, input logic [15:0] warps);
    wait_idle();
    write_reg(CFG_LDS, lds);
    write_reg(CFG_SGPR, sgpr);
    write_reg(CFG_VGPR, vgpr);
    write_reg(CFG_WARPS, warps);
    @(posedge clk);
  endtask

  initial begin
    wg_desc_t d;
    reset_scheduler();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue, stray opcode, largest and smallest workgroups,
    // queue overflow, all SMs taken, reload
    queue_request(OP_DISPATCH, '0);
    queue_request(OP_UNUSED, '1);
    queue_request(OP_ENQ, {12'hFFF, 12'hFFF, 16'hFFFF, 6'd32, 16'hFFFF});
    queue_request(OP_ENQ, '0);
    queue_request(OP_DISPATCH, '0);
    queue_request(OP_DISPATCH, '0);
    for (int i = 0; i < FIFO_DEPTH + 1; i++) begin
      d = '{vgpr: 12'(i * 300), sgpr: 12'(i * 450), lds: 16'(i * 7000),
            warps: 6'(i * 3 + 1), id: 16'(16'h1000 + i)};
      queue_request(OP_ENQ, d);
    end
    for (int i = 0; i < SM_COUNT - 1; i++) queue_request(OP_DISPATCH, '0);
    queue_request(OP_RELOAD, '0);
    queue_request(OP_DISPATCH, '0);
    queue_traffic(400);

    // tight resources, upper data bits beyond the register width dropped
    set_resources(16'd1000, 16'hA0C8, 16'd300, 16'd8);
    queue_request(OP_RELOAD, '0);
    queue_traffic(300);
    queue_request(OP_ENQ, '{vgpr: 12'd1, sgpr: 12'd1, lds: 16'd1, warps: 6'd9, id: 16'hBEEF});
    queue_request(OP_DISPATCH, '0);

    // largest settings: reload covers everything left waiting
    set_resources(16'hFFFF, 16'h0FFF, 16'h0FFF, 16'd32);
    queue_request(OP_RELOAD, '0);
    queue_request(OP_DISPATCH, '0);
    queue_traffic(250);

    // smallest settings
    set_resources(16'd0, 16'd0, 16'd0, 16'd1);
    queue_request(OP_RELOAD, '0);
    queue_traffic(80);

    // back to reset values written with noise above the register widths
    set_resources(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFE0);
    queue_request(OP_RELOAD, '0);
    queue_traffic(220);

    while (request_q.size() != 0 || placement_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
